// ----- design/cdks_pkg.sv -----
// Package: shared types and constants for the change-detecting keyed store.
package cdks_pkg;
	localparam int ENTRIES = 16;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam logic [1:0] CMD_UPDATE = 2'd0;
	localparam logic [1:0] CMD_FIND   = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam logic [3:0] ST_INSERTED  = 4'd0;
	localparam logic [3:0] ST_UPDATED   = 4'd1;
	localparam logic [3:0] ST_UNCHANGED = 4'd2;
	localparam logic [3:0] ST_IGNORED   = 4'd3;
	localparam logic [3:0] ST_DURFAIL   = 4'd4;
	localparam logic [3:0] ST_FOUND     = 4'd5;
	localparam logic [3:0] ST_NOTFOUND  = 4'd6;
	localparam logic [3:0] ST_QITEM     = 4'd7;
	localparam logic [3:0] ST_QEMPTY    = 4'd8;
	localparam logic [3:0] ST_FULL      = 4'd9;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  mod_key;
		logic [3:0]  level_id;
		logic [7:0]  func_key;
		logic [15:0] evt_key;
		logic [31:0] value;
		logic        force_req;
		logic [31:0] timestamp;
		logic        durable_ok;
		logic [3:0]  filter_mask;
	} cdks_in_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [7:0]  out_module;
		logic [3:0]  out_level;
		logic [7:0]  out_function;
		logic [15:0] out_event;
		logic [31:0] out_value;
		logic [31:0] out_time;
		logic        last;
		logic [4:0]  entry_count;
	} cdks_out_t;
endpackage

// ----- design/change_detecting_keyed_store_unit.sv -----
// Top level: key-sorted record table with update, find, query and clear.
// Each command takes one beat in and walks the table through a single shared
// key comparator and one memory port, reading and then comparing each record
// visited. An update or find stops at the first record whose key does not sort
// below its own, or past the last held record; an insert then shifts each record
// above the slot up one place, read and then written, and writes the new record.
// A query visits every held record and gives one result beat per match, or one
// empty result; each match is held until the next match or the end is found, and
// the walk resumes only once a released beat has been taken. Clear empties the
// table and gives no result. The block accepts no new beat until the last result
// beat of the current command has been taken.
module change_detecting_keyed_store_unit
	import cdks_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  cdks_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output cdks_out_t out_data
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_SHRD = 3'd3;
	localparam logic [2:0] S_SHWR = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;
	localparam logic [2:0] S_QOUT = 3'd6;

	logic [2:0]       state_q;
	cdks_in_t         req_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] idx_q;
	logic             found_q;
	logic             out_valid_q;
	cdks_out_t        out_q;

	// record memory: {key, value, time}
	logic [99:0] mem [ENTRIES];
	logic [99:0] rd_q;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [99:0]      wr_data;

	logic [35:0] req_key, ent_key;
	logic        key_lt, key_eq, q_match;
	logic [31:0] ent_val;

	assign req_key  = {req_q.mod_key, req_q.level_id, req_q.func_key, req_q.evt_key};
	assign ent_key  = rd_q[99:64];
	assign ent_val  = rd_q[63:32];
	// shared comparator
	assign key_lt = ent_key < req_key;
	assign key_eq = ent_key == req_key;
	assign q_match = (!req_q.filter_mask[0] || ent_key[35:28] == req_key[35:28]) &&
		(!req_q.filter_mask[1] || ent_key[27:24] == req_key[27:24]) &&
		(!req_q.filter_mask[2] || ent_key[23:16] == req_key[23:16]) &&
		(!req_q.filter_mask[3] || ent_key[15:0] == req_key[15:0]);

	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// memory port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// sequencer
	always_comb begin
		rd_addr = idx_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		wr_data = rd_q;
		case (state_q)
			S_SHRD: rd_addr = IDX_W'(idx_q - 1'b1);
			S_SHWR: begin
				// copy the lower neighbour up, or drop the new record in place
				if (found_q) begin
					wr_en   = 1'b1;
					wr_data = {req_key, req_q.value, req_q.timestamp};
				end else begin
					wr_en   = 1'b1;
				end
			end
			S_CMP: begin
				if (req_q.command == CMD_UPDATE && idx_q < used_q && key_eq &&
					ent_val != req_q.value && req_q.durable_ok) begin
					wr_en   = 1'b1;
					wr_data = {req_key, req_q.value, req_q.timestamp};
				end
			end
			default: ;
		endcase
	end

	function automatic cdks_out_t mk_out(logic [3:0] st, logic rec, logic [99:0] r,
		logic lst, logic [CNT_W-1:0] cnt);
		cdks_out_t o;
		o = '0;
		o.status = st;
		if (rec) begin
			o.out_module   = r[99:92];
			o.out_level    = r[91:88];
			o.out_function = r[87:80];
			o.out_event    = r[79:64];
			o.out_value    = r[63:32];
			o.out_time     = r[31:0];
		end
		o.last = lst;
		o.entry_count = 5'(cnt);
		return o;
	endfunction

	logic [CNT_W-1:0] pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			used_q      <= '0;
			idx_q       <= '0;
			pos_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						req_q   <= in_data;
						idx_q   <= '0;
						found_q <= 1'b0;
						if (in_data.command == CMD_CLEAR) begin
							used_q <= '0;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					if (req_q.command == CMD_QUERY) begin
						// walk all records; hold each match until the next one or the end
						if (idx_q >= used_q) begin
							if (found_q) begin
								out_q.last <= 1'b1;
							end else begin
								out_q <= mk_out(ST_QEMPTY, 1'b0, rd_q, 1'b1, used_q);
							end
							out_valid_q <= 1'b1;
							state_q     <= S_OUT;
						end else if (q_match && found_q) begin
							// release the held match, take this one once it has gone
							out_valid_q <= 1'b1;
							state_q     <= S_QOUT;
						end else if (q_match) begin
							out_q   <= mk_out(ST_QITEM, 1'b1, rd_q, 1'b0, used_q);
							found_q <= 1'b1;
							idx_q   <= idx_q + 1'b1;
							state_q <= S_RD;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_RD;
						end
					end else if (idx_q < used_q && key_lt) begin
						// advance the lower-bound search
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end else if (idx_q < used_q && key_eq) begin
						state_q     <= S_OUT;
						out_valid_q <= 1'b1;
						if (req_q.command == CMD_FIND) begin
							out_q <= mk_out(ST_FOUND, 1'b1, rd_q, 1'b1, used_q);
						end else if (ent_val == req_q.value) begin
							out_q <= mk_out(ST_UNCHANGED, 1'b1, rd_q, 1'b1, used_q);
						end else if (!req_q.durable_ok) begin
							out_q <= mk_out(ST_DURFAIL, 1'b0, rd_q, 1'b1, used_q);
						end else begin
							out_q <= mk_out(ST_UPDATED, 1'b1,
								{req_key, req_q.value, req_q.timestamp}, 1'b1, used_q);
						end
					end else if (req_q.command == CMD_UPDATE &&
						!(req_q.value == '0 && !req_q.force_req) &&
						used_q < CNT_W'(ENTRIES) && req_q.durable_ok) begin
						// insert: shift upward from the top
						pos_q   <= idx_q;
						idx_q   <= used_q;
						state_q <= (used_q == idx_q) ? S_SHWR : S_SHRD;
						found_q <= (used_q == idx_q);
					end else begin
						state_q     <= S_OUT;
						out_valid_q <= 1'b1;
						if (req_q.command == CMD_FIND) begin
							out_q <= mk_out(ST_NOTFOUND, 1'b0, rd_q, 1'b1, used_q);
						end else if (req_q.value == '0 && !req_q.force_req) begin
							out_q <= mk_out(ST_IGNORED, 1'b0, rd_q, 1'b1, used_q);
						end else if (used_q >= CNT_W'(ENTRIES)) begin
							out_q <= mk_out(ST_FULL, 1'b0, rd_q, 1'b1, used_q);
						end else begin
							out_q <= mk_out(ST_DURFAIL, 1'b0, rd_q, 1'b1, used_q);
						end
					end
				end
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					if (found_q) begin
						used_q      <= used_q + 1'b1;
						out_q <= mk_out(ST_INSERTED, 1'b1,
							{req_key, req_q.value, req_q.timestamp}, 1'b1, used_q + 1'b1);
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else begin
						idx_q   <= idx_q - 1'b1;
						found_q <= (idx_q - 1'b1) == pos_q;
						state_q <= ((idx_q - 1'b1) == pos_q) ? S_SHWR : S_SHRD;
					end
				end
				S_QOUT: begin
					// once the released beat is taken, hold the current match
					if (out_valid_q && out_ready) begin
						out_q       <= mk_out(ST_QITEM, 1'b1, rd_q, 1'b0, used_q);
						out_valid_q <= 1'b0;
						idx_q       <= idx_q + 1'b1;
						state_q     <= S_RD;
					end
				end
				S_OUT: begin
					if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- design/cdks_checker.sv -----
// Checker: port-level properties of the keyed store, with its bind.
module cdks_port_props
	import cdks_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input cdks_in_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input cdks_out_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat dropped or changed while stalled");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.entry_count <= 5'(ENTRIES))
		else $error("entry count above capacity");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ST_FULL)
		else $error("undefined status");
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_QITEM |-> out_data.last)
		else $error("non-query result without last");
endmodule

bind change_detecting_keyed_store_unit cdks_port_props u_cdks_props (.*);
